>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the voxel painter.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EVP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define EVP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EVP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define EVP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/evp_pkg.sv
// Package of the ellipsoid voxel painter: sizes, codes and shared types.
// Used by every module of the block except the generic RAM.
`timescale 1ns / 1ps
package evp_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 64;
  localparam int VOL_WORDS = MAX_X * MAX_Y * MAX_Z;
  localparam int VOL_AW = $clog2(VOL_WORDS);

  localparam int CW   = 6;   // center coordinate
  localparam int DW   = 16;  // diameter, Q8.8
  localparam int VW   = 16;  // voxel edge length, Q8.8
  localparam int SW   = 7;   // size register
  localparam int FW   = 32;  // voxel word
  localparam int CNTW = 19;  // fill counters
  localparam int RIW  = 18;  // read index
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam int FRAC  = 24;
  localparam int TERMW = FRAC + 1;
  localparam int TABW  = TERMW + 1;  // reject flag and term
  localparam logic [TERMW-1:0] FIX_ONE = TERMW'(1) << FRAC;
  localparam int NPW = 2 * CW + 2 * VW + 2;

  localparam int QDEPTH = 2;
  localparam int QPW = $clog2(QDEPTH);
  localparam int TAB_DEPTH = QDEPTH * (1 << CW);
  localparam int TAB_AW = QPW + CW;

  localparam logic [CNTW-1:0] CNT_SAT = '1;

  localparam logic [CFG_IW-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_VLEN_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VLEN_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_VLEN_Z = 3'd5;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Effective configuration: sizes already clamped, lengths never zero.
  typedef struct packed {
    logic [2:0][SW-1:0] size;
    logic [2:0][VW-1:0] vlen;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic               empty;
    logic [QPW-1:0]     slot;
    logic [2:0][CW-1:0] ctr;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic [FW-1:0]      fill;
    logic               last;
    logic [RIW-1:0]     ridx;
  } qent_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QPW-1:0] wr_slot;
  } qstat_t;

  typedef struct packed {
    logic clearing;
  } bstat_t;

  typedef struct packed {
    logic [2:0]        we;
    logic [TAB_AW-1:0] addr;
    logic [TABW-1:0]   data;
  } tabw_t;

endpackage

>>> rtl/core/evp_ram.sv
// Generic single write, single read RAM with registered read data.
// Stands alone; no package needed.
`timescale 1ns / 1ps
module evp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/evp_front.sv
// Front end: accepts items, finds the clamped bounding box and fills the
// per-axis term tables. Depends on evp_pkg.
`timescale 1ns / 1ps
module evp_front import evp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  logic           cmd,
  input  logic [CW-1:0]  center_x,
  input  logic [CW-1:0]  center_y,
  input  logic [CW-1:0]  center_z,
  input  logic [DW-1:0]  diam_x,
  input  logic [DW-1:0]  diam_y,
  input  logic [DW-1:0]  diam_z,
  input  logic [FW-1:0]  fill_value,
  input  logic           last_of_batch,
  input  logic [RIW-1:0] read_index,
  input  cfg_t           cfg,
  input  qstat_t         qstat,
  input  bstat_t         bstat,
  output logic           push,
  output qent_t          push_ent,
  output tabw_t          tabw
);

  typedef enum logic [3:0] {
    F_IDLE, F_RSET, F_LO, F_HI, F_DIV, F_RND, F_NXT, F_CHK,
    F_TSET, F_TSQ, F_TMUL, F_TCMP, F_TDIV, F_TNXT, F_PUSH
  } state_t;

  state_t             state;
  qent_t              ent;
  logic [2:0][DW-1:0] diam;
  logic [1:0]         ax;
  logic [VW:0]        q;
  logic [VW+CW:0]     qc;
  logic [VW+SW:0]     sq;
  logic [VW+CW+1:0]   div_num;
  logic [CW-1:0]      div_q;
  logic [2:0]         div_bit;
  logic               div_hi;
  logic [2*VW+1:0]    vv4;
  logic [2*DW-1:0]    dd;
  logic [CW-1:0]      off;
  logic [CW-1:0]      amax;
  logic [2*CW-1:0]    osq;
  logic [NPW-1:0]     nprod;
  logic [2*DW-1:0]    rem;
  logic [TERMW-1:0]   quo;
  logic [4:0]         tbit;

  logic [CW-1:0]      cur_c;
  logic [DW-1:0]      cur_d;
  logic [VW-1:0]      cur_v;
  logic [SW-1:0]      cur_sz;
  logic [VW:0]        q_c;
  logic [VW+CW+1:0]   phi;
  logic [VW+CW+1:0]   qs;
  logic [VW+1:0]      r2;
  logic               inc;
  logic [CW-1:0]      fr;
  logic [CW-1:0]      span_lo;
  logic [CW-1:0]      span_hi;
  logic [2*DW:0]      dr2;
  logic               dge;
  logic [2*DW-1:0]    rem_n;
  logic [TERMW-1:0]   quo_n;
  logic               bad_box;

  always_comb begin
    cur_c   = ent.ctr[ax];
    cur_d   = diam[ax];
    cur_v   = cfg.vlen[ax];
    cur_sz  = cfg.size[ax];
    q_c     = {cur_v, 1'b0};
    phi     = (VW + CW + 2)'(qc) + (VW + CW + 2)'(cur_d);
    qs      = (VW + CW + 2)'(q) << div_bit;
    r2      = {div_num[VW:0], 1'b0};
    inc     = (r2 > (VW + 2)'(q)) || ((r2 == (VW + 2)'(q)) && div_q[0]);
    fr      = div_q + CW'(inc);
    span_lo = cur_c - ent.lo[ax];
    span_hi = (ent.hi[ax] > cur_c) ? (ent.hi[ax] - cur_c) : '0;
    dr2     = {rem, 1'b0};
    dge     = dr2 >= {1'b0, dd};
    rem_n   = dge ? (2 * DW)'(dr2 - {1'b0, dd}) : dr2[2*DW-1:0];
    quo_n   = {quo[TERMW-2:0], dge};
    bad_box = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (ent.lo[a] > ent.hi[a]) begin
        bad_box = 1'b1;
      end
    end
  end

  assign cmd_stall = (state != F_IDLE) || qstat.full || bstat.clearing;
  assign push      = (state == F_PUSH);
  assign push_ent  = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      tabw.we <= '0;
    end else begin
      tabw.we <= '0;
      unique case (state)
        F_IDLE: begin
          if (cmd_valid && !cmd_stall) begin
            ent.cmd   <= cmd;
            ent.empty <= 1'b0;
            ent.slot  <= qstat.wr_slot;
            ent.ctr   <= {center_z, center_y, center_x};
            ent.lo    <= '0;
            ent.hi    <= '0;
            ent.fill  <= fill_value;
            ent.last  <= last_of_batch;
            ent.ridx  <= read_index;
            diam      <= {diam_z, diam_y, diam_x};
            ax        <= 2'd0;
            if (cmd == CMD_READ) begin
              state <= F_PUSH;
            end else if (diam_x == '0 || diam_y == '0 || diam_z == '0) begin
              ent.empty <= 1'b1;
              state     <= F_PUSH;
            end else begin
              state <= F_RSET;
            end
          end
        end
        F_RSET: begin
          q     <= q_c;
          qc    <= (VW + CW + 1)'(q_c) * (VW + CW + 1)'(cur_c);
          sq    <= (VW + SW + 1)'(cur_sz - SW'(1)) * (VW + SW + 1)'(q_c);
          state <= F_LO;
        end
        F_LO: begin
          if (qc <= (VW + CW + 1)'(cur_d)) begin
            ent.lo[ax] <= '0;
            state      <= F_HI;
          end else begin
            div_num <= (VW + CW + 2)'(qc) - (VW + CW + 2)'(cur_d);
            div_q   <= '0;
            div_bit <= 3'(CW - 1);
            div_hi  <= 1'b0;
            state   <= F_DIV;
          end
        end
        F_HI: begin
          if (phi >= (VW + CW + 2)'(sq)) begin
            ent.hi[ax] <= CW'(cur_sz - SW'(1));
            state      <= F_NXT;
          end else begin
            div_num <= phi;
            div_q   <= '0;
            div_bit <= 3'(CW - 1);
            div_hi  <= 1'b1;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_num >= qs) begin
            div_num        <= div_num - qs;
            div_q[div_bit] <= 1'b1;
          end
          if (div_bit == '0) begin
            state <= F_RND;
          end else begin
            div_bit <= div_bit - 3'd1;
          end
        end
        F_RND: begin
          if (div_hi) begin
            ent.hi[ax] <= fr;
            state      <= F_NXT;
          end else begin
            ent.lo[ax] <= fr;
            state      <= F_HI;
          end
        end
        F_NXT: begin
          if (ax == 2'd2) begin
            state <= F_CHK;
          end else begin
            ax    <= ax + 2'd1;
            state <= F_RSET;
          end
        end
        F_CHK: begin
          ax <= 2'd0;
          if (bad_box) begin
            ent.empty <= 1'b1;
            state     <= F_PUSH;
          end else begin
            state <= F_TSET;
          end
        end
        F_TSET: begin
          vv4   <= {(2 * VW)'(cur_v) * (2 * VW)'(cur_v), 2'b00};
          dd    <= (2 * DW)'(cur_d) * (2 * DW)'(cur_d);
          amax  <= (span_lo > span_hi) ? span_lo : span_hi;
          off   <= '0;
          state <= F_TSQ;
        end
        F_TSQ: begin
          osq   <= (2 * CW)'(off) * (2 * CW)'(off);
          state <= F_TMUL;
        end
        F_TMUL: begin
          nprod <= NPW'(osq) * NPW'(vv4);
          state <= F_TCMP;
        end
        F_TCMP: begin
          tabw.addr <= {ent.slot, off};
          if (nprod > NPW'(dd)) begin
            tabw.we[ax] <= 1'b1;
            tabw.data   <= {1'b1, TERMW'(0)};
            state       <= F_TNXT;
          end else if (nprod == NPW'(dd)) begin
            tabw.we[ax] <= 1'b1;
            tabw.data   <= {1'b0, FIX_ONE};
            state       <= F_TNXT;
          end else begin
            rem   <= nprod[2*DW-1:0];
            quo   <= '0;
            tbit  <= '0;
            state <= F_TDIV;
          end
        end
        F_TDIV: begin
          rem  <= rem_n;
          quo  <= quo_n;
          tbit <= tbit + 5'd1;
          if (tbit == 5'(FRAC - 1)) begin
            tabw.we[ax] <= 1'b1;
            tabw.data   <= {1'b0, quo_n};
            state       <= F_TNXT;
          end
        end
        F_TNXT: begin
          if (off == amax) begin
            if (ax == 2'd2) begin
              state <= F_PUSH;
            end else begin
              ax    <= ax + 2'd1;
              state <= F_TSET;
            end
          end else begin
            off   <= off + CW'(1);
            state <= F_TSQ;
          end
        end
        F_PUSH: begin
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/evp_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on evp_pkg.
`timescale 1ns / 1ps
module evp_queue import evp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qent_t  push_ent,
  input  logic   pop,
  output qent_t  head,
  output qstat_t qstat
);

  qent_t          mem [QDEPTH];
  logic [QPW-1:0] wp;
  logic [QPW-1:0] rp;
  logic [QPW:0]   cnt;

  assign head          = mem[rp];
  assign qstat.full    = (cnt == (QPW + 1)'(QDEPTH));
  assign qstat.empty   = (cnt == '0);
  assign qstat.wr_slot = wp;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QPW'(QDEPTH - 1)) ? '0 : wp + QPW'(1);
      end
      if (pop) begin
        rp <= (rp == QPW'(QDEPTH - 1)) ? '0 : rp + QPW'(1);
      end
      cnt <= cnt + (QPW + 1)'(push) - (QPW + 1)'(pop);
    end
  end

endmodule

>>> rtl/core/evp_back.sv
// Back end: clears the volume after reset, walks each bounding box one voxel
// a cycle, serves reads and keeps the batch total. Depends on evp_pkg.
`timescale 1ns / 1ps
module evp_back import evp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  qent_t                  head,
  input  qstat_t                 qstat,
  output logic                   pop,
  output bstat_t                 bstat,
  output logic                   vol_we,
  output logic [VOL_AW-1:0]      vol_waddr,
  output logic [FW-1:0]          vol_wdata,
  output logic [VOL_AW-1:0]      vol_raddr,
  input  logic [FW-1:0]          vol_rdata,
  output logic [2:0][TAB_AW-1:0] tab_raddr,
  input  logic [2:0][TABW-1:0]   tab_rdata,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [CNTW-1:0]        filled_now,
  output logic [CNTW-1:0]        filled_total,
  output logic [FW-1:0]          voxel_word
);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_WALK, B_DRAIN, B_RDATA, B_DONE
  } state_t;

  state_t             state;
  logic [VOL_AW-1:0]  clr_addr;
  logic [2:0][CW-1:0] pos;
  logic               s1_valid;
  logic [VOL_AW-1:0]  s1_addr;
  logic [CNTW-1:0]    cnt;
  logic [CNTW-1:0]    batch;
  logic [FW-1:0]      rd_word;

  logic [VOL_AW-1:0]  walk_addr;
  logic               walk_last;
  logic [TERMW+1:0]   tsum;
  logic               in_shape;
  logic               hit;
  logic               can_load;
  logic [CNTW:0]      tot_raw;
  logic [CNTW-1:0]    tot;

  always_comb begin
    walk_addr = VOL_AW'(pos[2]) * VOL_AW'(MAX_X * MAX_Y)
              + VOL_AW'(pos[1]) * VOL_AW'(MAX_X) + VOL_AW'(pos[0]);
    walk_last = (pos[0] == head.hi[0]) && (pos[1] == head.hi[1]) && (pos[2] == head.hi[2]);
    for (int a = 0; a < 3; a++) begin
      tab_raddr[a] = {head.slot,
                      (head.ctr[a] >= pos[a]) ? head.ctr[a] - pos[a] : pos[a] - head.ctr[a]};
    end
    tsum = (TERMW + 2)'(tab_rdata[0][TERMW-1:0]) + (TERMW + 2)'(tab_rdata[1][TERMW-1:0])
         + (TERMW + 2)'(tab_rdata[2][TERMW-1:0]);
    in_shape = !tab_rdata[0][TERMW] && !tab_rdata[1][TERMW] && !tab_rdata[2][TERMW]
             && (tsum <= (TERMW + 2)'(FIX_ONE));
    hit = s1_valid && in_shape && (vol_rdata == '0);
    if (state == B_CLEAR) begin
      vol_we    = 1'b1;
      vol_waddr = clr_addr;
      vol_wdata = '0;
    end else begin
      vol_we    = hit;
      vol_waddr = s1_addr;
      vol_wdata = head.fill;
    end
    vol_raddr = (state == B_IDLE && head.cmd == CMD_READ) ? VOL_AW'(head.ridx) : walk_addr;
    can_load  = !rsp_valid || !rsp_stall;
    tot_raw   = (CNTW + 1)'(batch) + (CNTW + 1)'(cnt);
    tot       = (tot_raw > (CNTW + 1)'(CNT_SAT)) ? CNT_SAT : tot_raw[CNTW-1:0];
  end

  assign pop            = (state == B_DONE) && can_load;
  assign bstat.clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      cnt       <= '0;
      batch     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (hit && cnt != CNT_SAT) begin
        cnt <= cnt + CNTW'(1);
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + VOL_AW'(1);
          if (clr_addr == VOL_AW'(VOL_WORDS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!qstat.empty) begin
            cnt <= '0;
            pos <= head.lo;
            if (head.cmd == CMD_READ) begin
              state <= B_RDATA;
            end else if (head.empty) begin
              state <= B_DONE;
            end else begin
              state <= B_WALK;
            end
          end
        end
        B_WALK: begin
          s1_valid <= 1'b1;
          s1_addr  <= walk_addr;
          if (pos[0] != head.hi[0]) begin
            pos[0] <= pos[0] + CW'(1);
          end else begin
            pos[0] <= head.lo[0];
            if (pos[1] != head.hi[1]) begin
              pos[1] <= pos[1] + CW'(1);
            end else begin
              pos[1] <= head.lo[1];
              pos[2] <= pos[2] + CW'(1);
            end
          end
          if (walk_last) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          state <= B_DONE;
        end
        B_RDATA: begin
          rd_word <= (32'(head.ridx) < VOL_WORDS) ? vol_rdata : '0;
          state   <= B_DONE;
        end
        B_DONE: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            if (head.cmd == CMD_READ) begin
              filled_now   <= '0;
              filled_total <= batch;
              voxel_word   <= rd_word;
            end else begin
              filled_now   <= cnt;
              filled_total <= tot;
              voxel_word   <= '0;
              batch        <= head.last ? '0 : tot;
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ellipsoid_voxel_painter.sv
// Ellipsoid voxel painter: keeps a 64x64x64 volume of 32-bit words and paints
// ellipsoids into it. After reset the volume is cleared one word a cycle, and
// until the clear is done no item is accepted (configuration writes still
// land). A draw item first passes the front end, which finds the bounding
// box with a six-step divider and then builds a table of squared-offset terms
// per axis: an offset outside the ellipsoid gets a reject flag, and one
// strictly inside it needs the 24-step fractional divider, for offsets 0 up to
// the half-width of the box. The back end then visits the box one voxel a
// cycle through the volume memory's single read and write port. A two-entry
// queue lets the front end prepare the next item while the back end paints,
// so the rate settles at the slower of the two. Each item yields exactly one
// result item.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ellipsoid_voxel_painter import evp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic              cmd,
  input  logic [CW-1:0]     center_x,
  input  logic [CW-1:0]     center_y,
  input  logic [CW-1:0]     center_z,
  input  logic [DW-1:0]     diam_x,
  input  logic [DW-1:0]     diam_y,
  input  logic [DW-1:0]     diam_z,
  input  logic [FW-1:0]     fill_value,
  input  logic              last_of_batch,
  input  logic [RIW-1:0]    read_index,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [CNTW-1:0]   filled_now,
  output logic [CNTW-1:0]   filled_total,
  output logic [FW-1:0]     voxel_word
);

  // Raw configuration registers as written.
  logic [2:0][SW-1:0] size_raw;
  logic [2:0][VW-1:0] vlen_raw;
  cfg_t               cfg;

  qstat_t             qstat;
  bstat_t             bstat;
  tabw_t              tabw;
  logic               push;
  logic               pop;
  qent_t              push_ent;
  qent_t              head;

  logic               vol_we;
  logic [VOL_AW-1:0]  vol_waddr;
  logic [FW-1:0]      vol_wdata;
  logic [VOL_AW-1:0]  vol_raddr;
  logic [FW-1:0]      vol_rdata;
  logic [2:0][TAB_AW-1:0] tab_raddr;
  logic [2:0][TABW-1:0]   tab_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_raw <= {SW'(MAX_Z), SW'(MAX_Y), SW'(MAX_X)};
      vlen_raw <= {VW'(256), VW'(256), VW'(256)};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_raw[0] <= cfg_data[SW-1:0];
        REG_SIZE_Y: size_raw[1] <= cfg_data[SW-1:0];
        REG_SIZE_Z: size_raw[2] <= cfg_data[SW-1:0];
        REG_VLEN_X: vlen_raw[0] <= cfg_data[VW-1:0];
        REG_VLEN_Y: vlen_raw[1] <= cfg_data[VW-1:0];
        REG_VLEN_Z: vlen_raw[2] <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // Sizes are held to 1..MAX per axis and a zero edge length is replaced by the raw value 1.
  always_comb begin
    cfg.size[0] = (size_raw[0] == '0) ? SW'(1) :
                  (size_raw[0] > SW'(MAX_X)) ? SW'(MAX_X) : size_raw[0];
    cfg.size[1] = (size_raw[1] == '0) ? SW'(1) :
                  (size_raw[1] > SW'(MAX_Y)) ? SW'(MAX_Y) : size_raw[1];
    cfg.size[2] = (size_raw[2] == '0) ? SW'(1) :
                  (size_raw[2] > SW'(MAX_Z)) ? SW'(MAX_Z) : size_raw[2];
    for (int a = 0; a < 3; a++) begin
      cfg.vlen[a] = (vlen_raw[a] == '0) ? VW'(1) : vlen_raw[a];
    end
  end

  evp_front u_front (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd,
    .center_x, .center_y, .center_z, .diam_x, .diam_y, .diam_z,
    .fill_value, .last_of_batch, .read_index,
    .cfg, .qstat, .bstat, .push, .push_ent, .tabw
  );

  evp_queue u_queue (
    .clk, .rst, .push, .push_ent, .pop, .head, .qstat
  );

  // One term table per axis, two slots deep so the front end can fill the
  // tables of the next draw while the back end reads the current ones.
  for (genvar a = 0; a < 3; a++) begin : g_tab
    evp_ram #(.WIDTH(TABW), .DEPTH(TAB_DEPTH)) u_tab (
      .clk, .we(tabw.we[a]), .waddr(tabw.addr), .wdata(tabw.data),
      .raddr(tab_raddr[a]), .rdata(tab_rdata[a])
    );
  end

  evp_ram #(.WIDTH(FW), .DEPTH(VOL_WORDS)) u_volume (
    .clk, .we(vol_we), .waddr(vol_waddr), .wdata(vol_wdata),
    .raddr(vol_raddr), .rdata(vol_rdata)
  );

  evp_back u_back (
    .clk, .rst, .head, .qstat, .pop, .bstat,
    .vol_we, .vol_waddr, .vol_wdata, .vol_raddr, .vol_rdata,
    .tab_raddr, .tab_rdata,
    .rsp_valid, .rsp_stall, .filled_now, .filled_total, .voxel_word
  );

  // No item enters while the volume is still being cleared.
  `EVP_ASSERT_IMP(a_no_accept_in_clear, clk, rst, cmd_valid && !cmd_stall, !bstat.clearing, "item accepted during clear")
  // The front end only hands over an item when the queue has room.
  `EVP_ASSERT_IMP(a_no_overflow, clk, rst, push, !qstat.full, "queue overflow")
  `EVP_ASSERT_NXT(a_push_lands, clk, rst, push, !qstat.empty, "pushed item missing from queue")
  // The batch total always includes the count of the current draw.
  `EVP_ASSERT_IMP(a_total_covers_now, clk, rst, rsp_valid, filled_now <= filled_total, "total below count")
  `EVP_ASSERT_IMP(a_read_no_count, clk, rst, rsp_valid && voxel_word != '0, filled_now == '0, "read with count")

endmodule
